>>> rtl/core/blq_pkg.sv
// shared types and constants for the bidirectional link queue
package blq_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int PAY_W          = 32;
    localparam int LIMIT_W        = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [1:0] {
        REQ_FROM_A = 2'd0,
        REQ_FROM_B = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_BAD    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CLS_NORMAL   = 2'd0,
        CLS_OVERRIDE = 2'd1,
        CLS_KILL     = 2'd2,
        CLS_SPARE    = 2'd3
    } class_t;

    typedef enum logic [2:0] {
        ACT_TO_B   = 3'd0,
        ACT_TO_A   = 3'd1,
        ACT_QUEUED = 3'd2,
        ACT_FULL   = 3'd3,
        ACT_KILL   = 3'd4,
        ACT_BAD    = 3'd5,
        ACT_IDLE   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        SEL_PAY  = 2'd0,
        SEL_RDA  = 2'd1,
        SEL_RDB  = 2'd2,
        SEL_ZERO = 2'd3
    } pay_sel_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

endpackage

>>> rtl/core/blq_fifo.sv
// one direction of the link: circular buffer with count and registered read
module blq_fifo #(
    parameter int DEPTH = blq_pkg::DEF_CAPACITY,
    parameter int WIDTH = blq_pkg::PAY_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  blq_pkg::fifo_ctrl_t        ctrl,
    input  logic [WIDTH-1:0]           wr_data,
    output logic [WIDTH-1:0]           rd_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;

    // wrap at the build depth
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            tail_next  = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
            count_next = count_reg + CW'(1);
        end
        if (ctrl.pop)
        begin
            head_next  = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= wr_data;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

>>> rtl/core/bidirectional_link_queue_unit.sv
// top level of the bidirectional link queue: two drop-tail fifos, one per direction
//
// requests: start with req_type, item_class and payload is taken at a clock edge
// where busy is low. side A and side B items are forwarded, queued or dropped;
// a tick forwards the head of each non-empty fifo, A-to-B first, or reports idle.
// results: out_valid marks action, out_payload and last for exactly one cycle;
// the receiver cannot stall, so nothing is ever held back on the result side.
// path: a request passes the input register, then the decision and fifo read into
// the result register, which drives the result ports; while busy is high it waits
// in the input register.
// throughput: one request per cycle while busy is low; a tick that serves both fifos
// gives two results and raises busy for one cycle, which holds back the next request.
// the result register is the limit.
// configuration: cfg_data is the queue limit, written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. write it only while idle.
// reset: both fifos empty, pointers at zero, queue limit 16, no result pending.
module bidirectional_link_queue_unit #(
    parameter int CAPACITY   = blq_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = blq_pkg::DEF_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic [1:0]                   item_class,
    input  logic [blq_pkg::PAY_W-1:0]    payload,
    output logic                         out_valid,
    output logic [2:0]                   action,
    output logic [blq_pkg::PAY_W-1:0]    out_payload,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [blq_pkg::LIMIT_W-1:0]  cfg_data
);

    localparam int SW = (DATA_WIDTH < blq_pkg::PAY_W) ? DATA_WIDTH : blq_pkg::PAY_W;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > blq_pkg::LIMIT_W) ? CW : blq_pkg::LIMIT_W;

    logic [blq_pkg::LIMIT_W-1:0] limit_reg;

    logic                s1_valid_reg;
    blq_pkg::req_t       s1_req_reg;
    blq_pkg::class_t     s1_class_reg;
    logic [SW-1:0]       s1_pay_reg;

    logic                s2_valid_reg, s2_valid_next;
    logic                s2_pair_reg, s2_pair_next;
    logic                s2_phase_reg, s2_phase_next;
    blq_pkg::action_t    s2_act_reg, s2_act_next;
    blq_pkg::pay_sel_t   s2_sel_reg, s2_sel_next;
    logic [SW-1:0]       s2_pay_reg;

    blq_pkg::fifo_ctrl_t ctrl_a, ctrl_b;
    logic [SW-1:0]       rd_a, rd_b;
    logic [CW-1:0]       count_a, count_b;

    logic advance;
    logic accept;
    logic full_a, full_b;
    logic has_a, has_b;
    logic pass_thru;

    assign advance   = !(s2_valid_reg && s2_pair_reg && !s2_phase_reg);
    assign busy      = !advance;
    assign accept    = start && advance;
    assign cfg_ready = 1'b1;

    assign pass_thru = (limit_reg == '0);
    assign full_a    = (LW'(count_a) >= LW'(limit_reg)) || (count_a == CW'(CAPACITY));
    assign full_b    = (LW'(count_b) >= LW'(limit_reg)) || (count_b == CW'(CAPACITY));
    assign has_a     = (count_a != '0);
    assign has_b     = (count_b != '0);

    // per-request decision
    always_comb
    begin
        ctrl_a        = '0;
        ctrl_b        = '0;
        s2_pair_next  = 1'b0;
        s2_act_next   = blq_pkg::ACT_BAD;
        s2_sel_next   = blq_pkg::SEL_PAY;
        case (s1_req_reg)
            blq_pkg::REQ_FROM_A, blq_pkg::REQ_FROM_B:
            begin
                if (s1_class_reg == blq_pkg::CLS_OVERRIDE || pass_thru)
                begin
                    s2_act_next = (s1_req_reg == blq_pkg::REQ_FROM_A) ?
                                  blq_pkg::ACT_TO_B : blq_pkg::ACT_TO_A;
                end
                else if (s1_class_reg == blq_pkg::CLS_KILL)
                begin
                    s2_act_next = blq_pkg::ACT_KILL;
                end
                else if (s1_req_reg == blq_pkg::REQ_FROM_A)
                begin
                    s2_act_next = full_a ? blq_pkg::ACT_FULL : blq_pkg::ACT_QUEUED;
                    ctrl_a.push = !full_a;
                end
                else
                begin
                    s2_act_next = full_b ? blq_pkg::ACT_FULL : blq_pkg::ACT_QUEUED;
                    ctrl_b.push = !full_b;
                end
            end
            blq_pkg::REQ_TICK:
            begin
                ctrl_a.pop = has_a;
                ctrl_b.pop = has_b;
                if (has_a)
                begin
                    s2_act_next  = blq_pkg::ACT_TO_B;
                    s2_sel_next  = blq_pkg::SEL_RDA;
                    s2_pair_next = has_b;
                end
                else if (has_b)
                begin
                    s2_act_next = blq_pkg::ACT_TO_A;
                    s2_sel_next = blq_pkg::SEL_RDB;
                end
                else
                begin
                    s2_act_next = blq_pkg::ACT_IDLE;
                    s2_sel_next = blq_pkg::SEL_ZERO;
                end
            end
            default:
            begin
                s2_act_next = blq_pkg::ACT_BAD;
            end
        endcase
        // only a request moving into the result register touches the fifos
        if (!(advance && s1_valid_reg))
        begin
            ctrl_a = '0;
            ctrl_b = '0;
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_phase_next = s2_phase_reg;
        if (advance)
        begin
            s2_valid_next = s1_valid_reg;
            s2_phase_next = 1'b0;
        end
        else
        begin
            s2_phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= blq_pkg::LIMIT_RESET;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_phase_reg <= 1'b0;
            s2_pair_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (advance)
            begin
                s1_valid_reg <= accept;
                s2_pair_reg  <= s2_pair_next && s1_valid_reg;
            end
            s2_valid_reg <= s2_valid_next;
            s2_phase_reg <= s2_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= blq_pkg::req_t'(req_type);
            s1_class_reg <= blq_pkg::class_t'(item_class);
            s1_pay_reg   <= payload[SW-1:0];
        end
        if (advance)
        begin
            s2_act_reg <= s2_act_next;
            s2_sel_reg <= s2_sel_next;
            s2_pay_reg <= s1_pay_reg;
        end
    end

    blq_fifo #(
        .DEPTH (CAPACITY),
        .WIDTH (SW)
    ) u_fifo_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl_a),
        .wr_data (s1_pay_reg),
        .rd_data (rd_a),
        .count   (count_a)
    );

    blq_fifo #(
        .DEPTH (CAPACITY),
        .WIDTH (SW)
    ) u_fifo_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl_b),
        .wr_data (s1_pay_reg),
        .rd_data (rd_b),
        .count   (count_b)
    );

    // second result of a two-sided tick is always the B-to-A head
    always_comb
    begin
        out_valid = s2_valid_reg;
        if (s2_phase_reg)
        begin
            action      = blq_pkg::ACT_TO_A;
            out_payload = blq_pkg::PAY_W'(rd_b);
            last        = 1'b1;
        end
        else
        begin
            action = s2_act_reg;
            last   = !s2_pair_reg;
            case (s2_sel_reg)
                blq_pkg::SEL_PAY:  out_payload = blq_pkg::PAY_W'(s2_pay_reg);
                blq_pkg::SEL_RDA:  out_payload = blq_pkg::PAY_W'(rd_a);
                blq_pkg::SEL_RDB:  out_payload = blq_pkg::PAY_W'(rd_b);
                default:           out_payload = '0;
            endcase
        end
    end

endmodule
